// File: rtl/core/lut3d_trilinear_color_map_top_assert.svh
// assertion macros for the 3d lut color mapper checker
`ifndef LUT3D_TRILINEAR_COLOR_MAP_TOP_ASSERT_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_TOP_ASSERT_SVH
// implication checked in the next cycle, off during reset
`define L3DCM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("l3dcm check failed");
// condition that must hold in the cycle after a reset cycle
`define L3DCM_ASSERT_AFTER_RESET(label, post) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error("l3dcm reset check failed");
`endif

// File: rtl/core/l3dcm_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers of the 3d lut color mapper
package l3dcm_pkg;
  localparam int MAX_GRID_DEF    = 33;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [5:0] GRID_RESET = 6'd33;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;
  // register index as seen on paddr[2]
  localparam logic REG_GRID = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // q0.wb weight of a remainder out of 255, rounded to nearest
  function automatic logic [31:0] weight_of(input int unsigned rem, input int unsigned wb);
    logic [63:0] num;
    num = (64'(rem) << wb) + 64'd127;
    return 32'(num / 64'd255);
  endfunction
endpackage

// File: rtl/core/lut3d_trilinear_color_map_top.sv
`timescale 1ns / 1ps
// top level of the 3d lut trilinear color mapper
//
// input channel (valid/ready): opcode 0 writes one table entry {blue, green, red}
// at table_index = r + n*g + n*n*b; opcode 1 maps one rgb pixel through the cube
// output channel (out_valid/out_ready): one item per pixel, none per table write;
// out_frame_end copies the pixel's frame_end mark
// apb register 0 (byte address 0): grid_size, points per axis, clamped to
// 2..MAX_GRID in use; reads back the low six bits of the written value
// throughput: one item per clock without stalls, table writes and pixels alike;
// the eight corner reads come from eight full table copies, one read port each
// register path: front, queue, offsets, ram, red, green and blue blends, output
// an entry must be written before any pixel reads it; a pixel may follow the
// write that fills its corners in the very next cycle
// reset clears all valid state and sets grid_size to 33; table contents are kept
// a stalled receiver holds the output register and freezes the back pipeline;
// the front keeps taking items until the four-entry queue fills
module lut3d_trilinear_color_map_top import l3dcm_pkg::*; #(
  parameter int MAX_GRID    = MAX_GRID_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        valid,
  output logic        ready,
  input  logic        opcode,
  input  logic [15:0] table_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_frame_end
);
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int IW = $clog2(MAX_GRID);
  localparam int QW = 2 + 16 + 24 + 6 * IW + 3 * WEIGHT_BITS;

  // configuration: raw register plus clamped grid and its square
  logic [5:0]      grid;
  logic [NW-1:0]   n;
  logic [2*NW-1:0] nn;
  logic [5:0]      g_src;
  logic [NW-1:0]   n_src;
  logic            cfg_we;

  // front to queue
  logic                    push;
  logic                    fr_op;
  logic                    fr_fe;
  logic [15:0]             fr_idx;
  logic [23:0]             fr_data;
  logic [2:0][IW-1:0]      fr_lo;
  logic [2:0][IW-1:0]      fr_hi;
  logic [2:0][WEIGHT_BITS-1:0] fr_w;

  // queue to back
  logic                    pop;
  q_stat_t                 stat;
  logic [QW-1:0]           push_data;
  logic [QW-1:0]           pop_data;
  logic                    q_op;
  logic                    q_fe;
  logic [15:0]             q_idx;
  logic [23:0]             q_data;
  logic [2:0][IW-1:0]      q_lo;
  logic [2:0][IW-1:0]      q_hi;
  logic [2:0][WEIGHT_BITS-1:0] q_w;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_GRID);
  assign prdata = (paddr[2] == REG_GRID) ? {26'd0, grid} : 32'd0;

  // clamp the grid size to the range the table supports
  assign g_src = rst ? GRID_RESET : pwdata[5:0];
  always_comb begin
    if (g_src < 6'd2) begin
      n_src = NW'(2);
    end else if (int'(g_src) > MAX_GRID) begin
      n_src = NW'(MAX_GRID);
    end else begin
      n_src = NW'(g_src);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      grid <= g_src;
      n    <= n_src;
      nn   <= (2*NW)'(n_src) * (2*NW)'(n_src);
    end
  end

  l3dcm_front #(
    .MAX_GRID    (MAX_GRID),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid),
    .ready       (ready),
    .opcode      (opcode),
    .table_index (table_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_end   (frame_end),
    .n           (n),
    .stat        (stat),
    .push        (push),
    .f_op        (fr_op),
    .f_fe        (fr_fe),
    .f_idx       (fr_idx),
    .f_data      (fr_data),
    .f_lo        (fr_lo),
    .f_hi        (fr_hi),
    .f_w         (fr_w)
  );

  assign push_data = {fr_op, fr_fe, fr_idx, fr_data, fr_lo, fr_hi, fr_w};
  assign {q_op, q_fe, q_idx, q_data, q_lo, q_hi, q_w} = pop_data;

  l3dcm_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  l3dcm_back #(
    .MAX_GRID    (MAX_GRID),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .stat          (stat),
    .pop           (pop),
    .q_op          (q_op),
    .q_fe          (q_fe),
    .q_idx         (q_idx),
    .q_data        (q_data),
    .q_lo          (q_lo),
    .q_hi          (q_hi),
    .q_w           (q_w),
    .n             (n),
    .nn            (nn),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );
endmodule

// File: rtl/core/l3dcm_ram.sv
`timescale 1ns / 1ps
// generic one write, one read ram with registered read
module l3dcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/l3dcm_queue.sv
`timescale 1ns / 1ps
// short register queue between the front and back parts
module l3dcm_queue import l3dcm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == (PW+1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// File: rtl/core/l3dcm_front.sv
`timescale 1ns / 1ps
// front part: takes items and splits each channel into cell index and weight
module l3dcm_front import l3dcm_pkg::*; #(
  parameter int MAX_GRID    = MAX_GRID_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   valid,
  output logic                                   ready,
  input  logic                                   opcode,
  input  logic [15:0]                            table_index,
  input  logic [7:0]                             red,
  input  logic [7:0]                             green,
  input  logic [7:0]                             blue,
  input  logic                                   frame_end,
  input  logic [$clog2(MAX_GRID+1)-1:0]          n,
  input  q_stat_t                                stat,
  output logic                                   push,
  output logic                                   f_op,
  output logic                                   f_fe,
  output logic [15:0]                            f_idx,
  output logic [23:0]                            f_data,
  output logic [2:0][$clog2(MAX_GRID)-1:0]       f_lo,
  output logic [2:0][$clog2(MAX_GRID)-1:0]       f_hi,
  output logic [2:0][WEIGHT_BITS-1:0]            f_w
);
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int IW = $clog2(MAX_GRID);
  localparam int PW = 8 + NW;

  logic                   f_valid;
  logic [2:0][7:0]        f_chan;
  logic [2:0][PW-1:0]     p;
  logic [2:0][PW:0]       qa;
  logic [2:0][7:0]        rem;
  logic [WEIGHT_BITS-1:0] wtab [256];

  for (genvar i = 0; i < 256; i++) begin : g_wtab
    assign wtab[i] = WEIGHT_BITS'(weight_of(i, WEIGHT_BITS));
  end

  assign ready  = !f_valid || !stat.full;
  assign push   = f_valid && !stat.full;
  assign f_data = f_chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      f_op   <= opcode;
      f_fe   <= frame_end;
      f_idx  <= table_index;
      f_chan <= {blue, green, red};
    end
  end

  // p / 255 for p below 255 * 256 is (p + (p >> 8) + 1) >> 8
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      p[ch]    = PW'(f_chan[ch]) * PW'(n - NW'(1));
      qa[ch]   = ({1'b0, p[ch]} + (PW+1)'(p[ch] >> 8) + (PW+1)'(1)) >> 8;
      rem[ch]  = 8'({1'b0, p[ch]} - ((qa[ch] << 8) - qa[ch]));
      f_lo[ch] = IW'(qa[ch]);
      f_hi[ch] = ((qa[ch] + (PW+1)'(1)) < (PW+1)'(n)) ? IW'(qa[ch] + (PW+1)'(1))
                                                      : IW'(n - NW'(1));
      f_w[ch]  = wtab[rem[ch]];
    end
  end
endmodule

// File: rtl/core/l3dcm_back.sv
`timescale 1ns / 1ps
// back part: table writes, eight corner reads and the trilinear blend
module l3dcm_back import l3dcm_pkg::*; #(
  parameter int MAX_GRID    = MAX_GRID_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  q_stat_t                            stat,
  output logic                               pop,
  input  logic                               q_op,
  input  logic                               q_fe,
  input  logic [15:0]                        q_idx,
  input  logic [23:0]                        q_data,
  input  logic [2:0][$clog2(MAX_GRID)-1:0]   q_lo,
  input  logic [2:0][$clog2(MAX_GRID)-1:0]   q_hi,
  input  logic [2:0][WEIGHT_BITS-1:0]        q_w,
  input  logic [$clog2(MAX_GRID+1)-1:0]      n,
  input  logic [2*$clog2(MAX_GRID+1)-1:0]    nn,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_frame_end
);
  localparam int IW    = $clog2(MAX_GRID);
  localparam int DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = WEIGHT_BITS;
  localparam int GW    = 8 + WB;
  localparam int TW    = GW + WB;
  localparam logic [TW:0] HALF_T = (TW+1)'(1) << (WB - 1);
  localparam logic [GW:0] HALF_C = (GW+1)'(1) << (WB - 1);

  function automatic logic [GW-1:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                           input logic [WB-1:0] w);
    logic signed [8:0]    d;
    logic signed [GW+1:0] acc;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    acc = $signed({2'b00, a, {WB{1'b0}}}) + d * $signed({1'b0, w});
    return acc[GW-1:0];
  endfunction

  function automatic logic [TW-1:0] blendw(input logic [GW-1:0] x, input logic [GW-1:0] y,
                                           input logic [WB-1:0] w);
    logic signed [GW:0]   d;
    logic signed [TW+1:0] acc;
    d   = $signed({1'b0, y}) - $signed({1'b0, x});
    acc = $signed({2'b00, x, {WB{1'b0}}}) + d * $signed({1'b0, w});
    return acc[TW-1:0];
  endfunction

  function automatic logic [GW-1:0] rnd(input logic [TW-1:0] t);
    logic [TW:0] s;
    s = {1'b0, t} + HALF_T;
    return s[WB +: GW];
  endfunction

  function automatic logic [7:0] to_byte(input logic [GW-1:0] c);
    logic [GW:0] s;
    s = {1'b0, c} + HALF_C;
    return s[WB +: 8];
  endfunction

  logic en;

  // stage 1: row and plane offsets
  logic                  v1;
  logic                  s1_op;
  logic                  s1_fe;
  logic [15:0]           s1_idx;
  logic [23:0]           s1_data;
  logic [IW-1:0]         s1_rlo;
  logic [IW-1:0]         s1_rhi;
  logic [1:0][AW-1:0]    s1_goff;
  logic [1:0][AW-1:0]    s1_boff;
  logic [2:0][WB-1:0]    s1_w;

  // stage 2: memory access
  logic [7:0][AW-1:0]    rd_addr;
  logic [7:0][23:0]      rd_data;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  v2;
  logic                  s2_fe;
  logic [2:0][WB-1:0]    s2_w;

  // stage 3: red blends
  logic [2:0][3:0][GW-1:0] gb;
  logic                    v3;
  logic                    s3_fe;
  logic [WB-1:0]           s3_w1;
  logic [WB-1:0]           s3_w2;
  logic [2:0][3:0][GW-1:0] s3_gb;

  // stage 4: green blends
  logic                    v4;
  logic                    s4_fe;
  logic [WB-1:0]           s4_w2;
  logic [2:0][1:0][TW-1:0] s4_t;

  // stage 5: blue blend
  logic                    v5;
  logic                    s5_fe;
  logic [2:0][TW-1:0]      s5_t;

  assign en  = !out_valid || out_ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop;
      v2        <= v1 && (s1_op == OP_PIXEL);
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op      <= q_op;
      s1_fe      <= q_fe;
      s1_idx     <= q_idx;
      s1_data    <= q_data;
      s1_rlo     <= q_lo[0];
      s1_rhi     <= q_hi[0];
      s1_goff[0] <= AW'(q_lo[1]) * AW'(n);
      s1_goff[1] <= AW'(q_hi[1]) * AW'(n);
      s1_boff[0] <= AW'(q_lo[2]) * AW'(nn);
      s1_boff[1] <= AW'(q_hi[2]) * AW'(nn);
      s1_w       <= q_w;
    end
  end

  assign ram_we    = en && v1 && (s1_op == OP_WRITE) && (32'(s1_idx) < 32'(DEPTH));
  assign ram_waddr = AW'(s1_idx);

  // corner c: bit 0 red upper, bit 1 green upper, bit 2 blue upper;
  // every bank holds a full copy so each corner has its own read port
  for (genvar c = 0; c < 8; c++) begin : g_bank
    assign rd_addr[c] = ((c % 2) != 0 ? AW'(s1_rhi) : AW'(s1_rlo))
                      + s1_goff[(c / 2) % 2] + s1_boff[c / 4];
    l3dcm_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (s1_data),
      .re    (en),
      .raddr (rd_addr[c]),
      .rdata (rd_data[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_fe <= s1_fe;
      s2_w  <= s1_w;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 4; k++) begin
        gb[ch][k] = blend8(rd_data[2*k][8*ch +: 8], rd_data[2*k+1][8*ch +: 8], s2_w[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fe <= s2_fe;
      s3_w1 <= s2_w[1];
      s3_w2 <= s2_w[2];
      s3_gb <= gb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_fe <= s3_fe;
      s4_w2 <= s3_w2;
      for (int ch = 0; ch < 3; ch++) begin
        s4_t[ch][0] <= blendw(s3_gb[ch][0], s3_gb[ch][1], s3_w1);
        s4_t[ch][1] <= blendw(s3_gb[ch][2], s3_gb[ch][3], s3_w1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_fe <= s4_fe;
      for (int ch = 0; ch < 3; ch++) begin
        s5_t[ch] <= blendw(rnd(s4_t[ch][0]), rnd(s4_t[ch][1]), s4_w2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_frame_end <= s5_fe;
      out_red       <= to_byte(rnd(s5_t[0]));
      out_green     <= to_byte(rnd(s5_t[1]));
      out_blue      <= to_byte(rnd(s5_t[2]));
    end
  end
endmodule

// File: rtl/core/l3dcm_checker.sv
`timescale 1ns / 1ps
// port-level checker of the 3d lut color mapper, bound to the top level
`include "lut3d_trilinear_color_map_top_assert.svh"
module l3dcm_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_frame_end
);
  // a stalled result holds
  `L3DCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_frame_end))
  // grid size reads back the low six bits of what was written
  `L3DCM_ASSERT_NEXT(a_grid_readback, psel && penable && pwrite && paddr == 3'd0, paddr != 3'd0 || prdata[5:0] == $past(pwdata[5:0]))
  // no result right after reset
  `L3DCM_ASSERT_AFTER_RESET(a_rst_out, !out_valid)
  // input side open right after reset
  `L3DCM_ASSERT_AFTER_RESET(a_rst_ready, ready)
endmodule

bind lut3d_trilinear_color_map_top l3dcm_port_checker u_checker (.*);

// File: dv/l3dcm_checker.sv
`timescale 1ns / 1ps
// watches the channels of the 3d lut color mapper, predicts each pixel and compares
module l3dcm_checker import l3dcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        valid,
  input  logic        ready,
  input  logic        opcode,
  input  logic [15:0] table_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_frame_end,
  output int          fail_count,
  output int          pending
);
  localparam int DEPTH = MAX_GRID_DEF * MAX_GRID_DEF * MAX_GRID_DEF;
  localparam int WB = WEIGHT_BITS_DEF;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } pixel_t;

  pixel_t      expected_pixels[$];
  logic [23:0] lut_copy [0:DEPTH-1];
  logic [5:0]  grid_reg;

  function automatic pixel_t map_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic fe);
    int unsigned       n, p, lo[3], hi[3], v[3], base, gi, bi;
    longint unsigned   w[3], gb[4], s, a, c0, c1, c, t;
    logic [7:0]        res[3];
    pixel_t            px;
    s = 64'd1 << WB;
    n = (grid_reg < 2) ? 2 : (grid_reg > MAX_GRID_DEF) ? MAX_GRID_DEF : grid_reg;
    v[0] = r;
    v[1] = g;
    v[2] = b;
    for (int k = 0; k < 3; k++) begin
      p = v[k] * (n - 1);
      lo[k] = p / 255;
      hi[k] = (lo[k] + 1 < n) ? lo[k] + 1 : n - 1;
      w[k] = ((longint'(p % 255) << WB) + 127) / 255;
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 4; k++) begin
        gi = (k & 1) ? hi[1] : lo[1];
        bi = (k & 2) ? hi[2] : lo[2];
        base = n * gi + n * n * bi;
        a = (lut_copy[base + lo[0]] >> (8 * ch)) & 8'hFF;
        t = (lut_copy[base + hi[0]] >> (8 * ch)) & 8'hFF;
        gb[k] = a * (s - w[0]) + t * w[0];
      end
      c0 = (gb[0] * (s - w[1]) + gb[1] * w[1] + (s >> 1)) >> WB;
      c1 = (gb[2] * (s - w[1]) + gb[3] * w[1] + (s >> 1)) >> WB;
      c = (c0 * (s - w[2]) + c1 * w[2] + (s >> 1)) >> WB;
      res[ch] = 8'((c + (s >> 1)) >> WB);
    end
    px.r = res[0];
    px.g = res[1];
    px.b = res[2];
    px.fe = fe;
    return px;
  endfunction

  initial fail_count = 0;
  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      grid_reg = GRID_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_GRID)
        grid_reg = pwdata[5:0];
      if (valid && ready) begin
        if (opcode == OP_WRITE) begin
          if (table_index < DEPTH) lut_copy[table_index] = {blue, green, red};
        end else begin
          expected_pixels.push_back(map_pixel(red, green, blue, frame_end));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result item with no pixel waiting");
          fail_count++;
        end else begin
          px = expected_pixels.pop_front();
          if (out_red !== px.r) begin
            $error("out_red expected %0d actual %0d", px.r, out_red);
            fail_count++;
          end
          if (out_green !== px.g) begin
            $error("out_green expected %0d actual %0d", px.g, out_green);
            fail_count++;
          end
          if (out_blue !== px.b) begin
            $error("out_blue expected %0d actual %0d", px.b, out_blue);
            fail_count++;
          end
          if (out_frame_end !== px.fe) begin
            $error("out_frame_end expected %0d actual %0d", px.fe, out_frame_end);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// stimulus, reset, watchdog and verdict for the 3d lut color mapper
module testbench;
  import l3dcm_pkg::*;

  localparam int DEPTH = MAX_GRID_DEF * MAX_GRID_DEF * MAX_GRID_DEF;
  localparam int DRAIN_CYCLES = 20;     // margin over the pipeline depth
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid = 1'b0;
  logic        ready;
  logic        opcode = OP_WRITE;
  logic [15:0] table_index = '0;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_frame_end;
  int          fail_count, pending;
  int          phase = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  int unsigned grid_use = 33;
  bit          written [DEPTH];

  always #6 clk = ~clk;

  lut3d_trilinear_color_map_top dut (.*);

  l3dcm_checker u_checker (.*);

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: one long hold-off in phase one, else a stall mode that changes often
  initial begin
    int mode;
    wait (phase == 1);
    @(negedge clk);
    out_ready = 1'b0;
    repeat (300) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    out_ready = 1'b1;
  end

  // register write: setup cycle, then access cycle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // offer one item, with bursts and random gaps between them
  task automatic send_item(input logic op, input logic [15:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic fe);
    if (burst_left == 0) begin
      @(negedge clk);
      valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    valid = 1'b1;
    opcode = op;
    table_index = idx;
    red = r;
    green = g;
    blue = b;
    frame_end = fe;
    items_sent++;
    if (op == OP_WRITE && int'(idx) < DEPTH) written[idx] = 1'b1;
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  // fill any corner the pixel needs that holds no entry yet, then send the pixel
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fe);
    int unsigned v[3], p, lo[3], hi[3], addr;
    v[0] = r;
    v[1] = g;
    v[2] = b;
    for (int k = 0; k < 3; k++) begin
      p = v[k] * (grid_use - 1);
      lo[k] = p / 255;
      hi[k] = (lo[k] + 1 < grid_use) ? lo[k] + 1 : grid_use - 1;
    end
    for (int c = 0; c < 8; c++) begin
      addr = (((c & 1) != 0) ? hi[0] : lo[0])
           + grid_use * (((c & 2) != 0) ? hi[1] : lo[1])
           + grid_use * grid_use * (((c & 4) != 0) ? hi[2] : lo[2]);
      if (!written[addr])
        send_item(OP_WRITE, 16'(addr), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom));
    end
    send_item(OP_PIXEL, 16'($urandom), r, g, b, fe);
  endtask

  // block idle: input lowered, results all back, pipeline flushed
  task automatic settle();
    @(negedge clk);
    valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [5:0] grids[8] = '{6'd33, 6'd2, 6'd0, 6'd63, 6'd1, 6'd7, 6'd17, 6'd32};
    int phase_start;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: out-of-range writes are dropped, extreme entries, extreme pixels
    send_item(OP_WRITE, 16'(DEPTH), 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(OP_WRITE, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(OP_WRITE, 16'd0, 8'hFF, 8'h00, 8'hFF, 1'b1);
    send_item(OP_WRITE, 16'(DEPTH - 1), 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd127, 8'd1, 1'b0);
    send_pixel(8'd254, 8'd8, 8'd247, 1'b1);
    // write then read the same corner right away
    send_item(OP_WRITE, 16'd0, 8'h12, 8'h34, 8'h56, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd3, 8'd2, 8'd1, 1'b0);

    // phases over several grid sizes, clamped values among them
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      apb_write({REG_GRID, 2'b00}, {$urandom} & 32'hFFFF_FFC0 | 32'(grids[ph]));
      grid_use = (grids[ph] < 6'd2) ? 2 : (int'(grids[ph]) > MAX_GRID_DEF) ?
                 MAX_GRID_DEF : grids[ph];
      phase = ph + 1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        else
          send_item(OP_WRITE, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                    : 16'($urandom_range(0, DEPTH - 1)),
                    8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
